// File: rtl/asa_pkg.sv
package asa_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 5;
	localparam int NUM_CHAN_REGS = 5;

	// Request codes carried in the kind field.
	localparam logic [1:0] KIND_CONV = 2'd0;
	localparam logic [1:0] KIND_RAW = 2'd1;
	localparam logic [1:0] KIND_AVG = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT0_CHAN = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT4_CHAN = 3'd5;

	localparam logic [4:0] BANDGAP_CHANNEL = 5'd16;
	localparam logic [5:0] COUNT_MAX = 6'd63;
	localparam logic [5:0] COUNT_HALF = 6'd32;

	// Shared divider: 22-bit dividend, 10-bit divisor, one quotient bit per cycle.
	localparam int DIV_W = 22;
	localparam logic [DIV_W-1:0] VCC_SCALE = 22'd1126400;
	localparam logic [4:0] DIV_LAST = 5'd21;

	typedef struct packed {
		logic [1:0] kind;
		logic [9:0] sample;
		logic [2:0] slot;
	} in_word_t;

	typedef struct packed {
		logic        sample_kept;
		logic [4:0]  next_channel;
		logic [9:0]  raw_value;
		logic [20:0] vcc_millivolts;
		logic [15:0] average_q6;
		logic        average_valid;
		logic [5:0]  sample_count;
	} out_word_t;

	// The bandgap code passes as it is; any other code reports its low four bits.
	function automatic logic [4:0] chan_code(input logic [4:0] ch);
		logic [4:0] code;
		if (ch == BANDGAP_CHANNEL) begin
			code = BANDGAP_CHANNEL;
		end else begin
			code = {1'b0, ch[3:0]};
		end
		return code;
	endfunction

endpackage

// File: rtl/adc_scan_averager.sv
// Channel   Handshake             Word
// in        in_valid / in_stall   asa_pkg::in_word_t   (kind, sample, slot)
// out       out_valid / out_stall asa_pkg::out_word_t  (one result word per input word)
// cfg       cfg_we                cfg_index selects the register, cfg_data holds the value
//
// A conversion or a read without division passes the fetch, execute and done states (an
// ignored word goes straight to done); a read that divides also passes the shared
// restoring divider, which produces one of its 22 quotient bits per cycle.
// arst_n clears the configuration, all per-slot storage and the scan state.
// The input is stalled while a word is in work; a finished word waits in the output
// register, and a new input word is taken while it waits.
module adc_scan_averager #(
	parameter int MAX_SLOTS = 5,
	parameter int SETTLE_READS = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  asa_pkg::in_word_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output asa_pkg::out_word_t                out_data,
	input  logic                              cfg_we,
	input  logic [asa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [asa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SW = $clog2(SETTLE_READS + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_DIVIDE, ST_DONE} state_t;

	state_t state_q;

	logic [2:0] slot_count_q;
	logic [4:0] chan_q [asa_pkg::NUM_CHAN_REGS];

	logic [9:0]  raw_mem [MAX_SLOTS];
	logic [15:0] sum_mem [MAX_SLOTS];
	logic [5:0]  cnt_mem [MAX_SLOTS];

	logic [SW-1:0] settle_q;
	logic [2:0]    scan_index_q;

	logic [1:0]    kind_q;
	logic [9:0]    sample_q;
	logic [AW-1:0] addr_q;
	logic [9:0]    rd_raw_q;
	logic [15:0]   rd_sum_q;
	logic [5:0]    rd_cnt_q;
	asa_pkg::out_word_t res_q;

	logic [asa_pkg::DIV_W-1:0] dq_q;
	logic [9:0] rem_q;
	logic [9:0] dvs_q;
	logic [4:0] step_q;

	logic               out_valid_q;
	asa_pkg::out_word_t out_data_q;

	// Combinational helpers.
	logic [2:0]  n_act;
	logic [2:0]  idx_eff;
	logic [2:0]  idx_nxt;
	logic [4:0]  chan_eff;
	logic [4:0]  chan_nxt;
	logic [SW-1:0] settle_nxt;
	logic [15:0] sum_add;
	logic [10:0] rem_sh;
	logic        div_ge;
	logic [10:0] rem_diff;
	logic [asa_pkg::DIV_W-1:0] quot_nxt;
	logic [2:0]  cfg_slot;

	always_comb begin
		n_act = (int'(slot_count_q) > MAX_SLOTS) ? 3'(MAX_SLOTS) : slot_count_q;
		idx_eff = (scan_index_q >= n_act) ? 3'd0 : scan_index_q;
		idx_nxt = (idx_eff + 3'd1 == n_act) ? 3'd0 : idx_eff + 3'd1;
		chan_eff = (int'(idx_eff) < asa_pkg::NUM_CHAN_REGS) ?
			asa_pkg::chan_code(chan_q[idx_eff]) : 5'd0;
		chan_nxt = (int'(idx_nxt) < asa_pkg::NUM_CHAN_REGS) ?
			asa_pkg::chan_code(chan_q[idx_nxt]) : 5'd0;
		settle_nxt = settle_q + SW'(1);
		sum_add = rd_sum_q + {6'd0, sample_q};
		rem_sh = {rem_q, dq_q[asa_pkg::DIV_W-1]};
		div_ge = (rem_sh >= {1'b0, dvs_q});
		rem_diff = rem_sh - {1'b0, dvs_q};
		quot_nxt = {dq_q[asa_pkg::DIV_W-2:0], div_ge};
		cfg_slot = cfg_index - asa_pkg::REG_SLOT0_CHAN;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_count_q <= '0;
			for (int c = 0; c < asa_pkg::NUM_CHAN_REGS; c++) begin
				chan_q[c] <= '0;
			end
			for (int i = 0; i < MAX_SLOTS; i++) begin
				raw_mem[i] <= '0;
				sum_mem[i] <= '0;
				cnt_mem[i] <= '0;
			end
			settle_q <= '0;
			scan_index_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The done state loads the output register itself.
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q <= in_data.kind;
						sample_q <= in_data.sample;
						res_q <= '0;
						state_q <= ST_DONE;
						if (in_data.kind == asa_pkg::KIND_CONV) begin
							if (n_act != 3'd0) begin
								addr_q <= AW'(idx_eff);
								state_q <= ST_FETCH;
							end
						end else if (in_data.kind == asa_pkg::KIND_RAW ||
							in_data.kind == asa_pkg::KIND_AVG) begin
							if (int'(in_data.slot) < MAX_SLOTS) begin
								addr_q <= AW'(in_data.slot);
								state_q <= ST_FETCH;
							end
						end
					end
				end
				ST_FETCH: begin
					rd_raw_q <= raw_mem[addr_q];
					rd_sum_q <= sum_mem[addr_q];
					rd_cnt_q <= cnt_mem[addr_q];
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					rem_q <= '0;
					step_q <= '0;
					if (kind_q == asa_pkg::KIND_CONV) begin
						if (settle_nxt < SW'(SETTLE_READS)) begin
							// Still settling after the channel switch: drop the word.
							settle_q <= settle_nxt;
							scan_index_q <= idx_eff;
							res_q.next_channel <= chan_eff;
						end else begin
							raw_mem[addr_q] <= sample_q;
							if (rd_cnt_q >= asa_pkg::COUNT_MAX) begin
								sum_mem[addr_q] <= {1'b0, sum_add[15:1]};
								cnt_mem[addr_q] <= asa_pkg::COUNT_HALF;
							end else begin
								sum_mem[addr_q] <= sum_add;
								cnt_mem[addr_q] <= rd_cnt_q + 6'd1;
							end
							settle_q <= '0;
							scan_index_q <= idx_nxt;
							res_q.sample_kept <= 1'b1;
							res_q.next_channel <= chan_nxt;
						end
					end else if (kind_q == asa_pkg::KIND_RAW) begin
						res_q.raw_value <= rd_raw_q;
						dq_q <= asa_pkg::VCC_SCALE;
						dvs_q <= rd_raw_q;
						if (rd_raw_q != 10'd0) begin
							state_q <= ST_DIVIDE;
						end
					end else begin
						sum_mem[addr_q] <= '0;
						cnt_mem[addr_q] <= '0;
						dq_q <= {rd_sum_q, 6'd0};
						dvs_q <= {4'd0, rd_cnt_q};
						if (rd_cnt_q != 6'd0) begin
							res_q.average_valid <= 1'b1;
							res_q.sample_count <= rd_cnt_q;
							state_q <= ST_DIVIDE;
						end
					end
				end
				ST_DIVIDE: begin
					dq_q <= quot_nxt;
					rem_q <= div_ge ? rem_diff[9:0] : rem_sh[9:0];
					step_q <= step_q + 5'd1;
					if (step_q == asa_pkg::DIV_LAST) begin
						if (kind_q == asa_pkg::KIND_RAW) begin
							res_q.vcc_millivolts <= quot_nxt[20:0];
						end else begin
							res_q.average_q6 <= quot_nxt[15:0];
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_data_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Register writes must arrive only while no word is in work; the block itself does not enforce this.
			if (cfg_we) begin
				unique case (cfg_index) inside
					asa_pkg::REG_SLOT_COUNT: begin
						if (cfg_data[2:0] != slot_count_q) begin
							scan_index_q <= '0;
						end
						slot_count_q <= cfg_data[2:0];
					end
					[asa_pkg::REG_SLOT0_CHAN:asa_pkg::REG_SLOT4_CHAN]: begin
						if (cfg_data != chan_q[cfg_slot]) begin
							chan_q[cfg_slot] <= cfg_data;
							if (int'(cfg_slot) < MAX_SLOTS) begin
								sum_mem[AW'(cfg_slot)] <= '0;
								cnt_mem[AW'(cfg_slot)] <= '0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The partial remainder must stay below the divisor on every step.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

	// A kept conversion result never carries a raw value or a valid average.
	a_conv_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sample_kept |->
			out_data.raw_value == 10'd0 && !out_data.average_valid)
		else $error("kept conversion carries read fields");

	// A valid average always comes with a nonzero sample count.
	a_avg_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.average_valid |-> out_data.sample_count != 6'd0)
		else $error("valid average with zero count");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int NUM_SLOTS = 5;
	localparam int SETTLE_READS = 2;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [asa_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [asa_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	asa_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	asa_pkg::out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [asa_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [asa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the scanner: configuration and per-slot storage.
	logic [2:0] slot_count_q;
	logic [4:0] chan_q [NUM_SLOTS];
	logic [9:0] raw_q [NUM_SLOTS];
	logic [15:0] sum_q [NUM_SLOTS];
	logic [5:0] count_q [NUM_SLOTS];
	int settle_q;
	logic [2:0] scan_q;

	asa_pkg::out_word_t pending_results[$];
	asa_pkg::out_word_t oldest_result;
	int mismatch_count = 0;
	int cycle_count = 0;
	int stall_pct = 0;
	int stall_run = 0;
	int gap_max = 0;
	int burst_left = 1;

	adc_scan_averager dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The receiver stalls in short runs; stall_pct sets how often a run starts.
	always @(posedge clk) begin
		if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if ($urandom_range(99, 0) < stall_pct) begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(6, 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [4:0] reported_channel(input logic [2:0] s);
		logic [4:0] ch;
		ch = chan_q[s];
		if (ch == asa_pkg::BANDGAP_CHANNEL) begin
			return ch;
		end
		return {1'b0, ch[3:0]};
	endfunction

	function automatic void apply_reg_write(input logic [2:0] idx, input logic [4:0] val);
		int s;
		if (idx == asa_pkg::REG_SLOT_COUNT) begin
			if (val[2:0] != slot_count_q) begin
				scan_q = '0;
			end
			slot_count_q = val[2:0];
		end else if (idx >= asa_pkg::REG_SLOT0_CHAN && idx <= asa_pkg::REG_SLOT4_CHAN) begin
			s = idx - asa_pkg::REG_SLOT0_CHAN;
			if (val != chan_q[s]) begin
				chan_q[s] = val;
				sum_q[s] = '0;
				count_q[s] = '0;
			end
		end
	endfunction

	function automatic asa_pkg::out_word_t scan_and_average(input asa_pkg::in_word_t w);
		asa_pkg::out_word_t r;
		int active;
		int s;
		r = '0;
		active = (slot_count_q > NUM_SLOTS) ? NUM_SLOTS : slot_count_q;
		s = w.slot;
		if (w.kind == asa_pkg::KIND_CONV) begin
			if (active == 0) begin
				return r;
			end
			if (scan_q >= active) begin
				scan_q = '0;
			end
			settle_q++;
			// Still settling on the new channel: the same slot stays selected.
			if (settle_q < SETTLE_READS) begin
				r.next_channel = reported_channel(scan_q);
				return r;
			end
			raw_q[scan_q] = w.sample;
			sum_q[scan_q] = sum_q[scan_q] + w.sample;
			if (count_q[scan_q] >= asa_pkg::COUNT_MAX) begin
				sum_q[scan_q] = sum_q[scan_q] >> 1;
				count_q[scan_q] = asa_pkg::COUNT_HALF;
			end else begin
				count_q[scan_q] = count_q[scan_q] + 1'b1;
			end
			settle_q = 0;
			scan_q = 3'((int'(scan_q) + 1) % active);
			r.sample_kept = 1'b1;
			r.next_channel = reported_channel(scan_q);
		end else if (w.kind == KIND_UNUSED || s >= NUM_SLOTS) begin
			return r;
		end else if (w.kind == asa_pkg::KIND_RAW) begin
			r.raw_value = raw_q[s];
			if (raw_q[s] != 0) begin
				r.vcc_millivolts = 21'(32'(asa_pkg::VCC_SCALE) / raw_q[s]);
			end
		end else begin
			if (count_q[s] != 0) begin
				r.average_q6 = 16'((32'(sum_q[s]) * 64) / count_q[s]);
				r.average_valid = 1'b1;
				r.sample_count = count_q[s];
			end
			sum_q[s] = '0;
			count_q[s] = '0;
		end
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 40) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 40) begin
					$display("%0t: word %h arrived with nothing expected", $time, out_data);
				end
			end else begin
				oldest_result = pending_results.pop_front();
				compare_field("sample_kept", oldest_result.sample_kept, out_data.sample_kept);
				compare_field("next_channel", oldest_result.next_channel, out_data.next_channel);
				compare_field("raw_value", oldest_result.raw_value, out_data.raw_value);
				compare_field("vcc_millivolts", oldest_result.vcc_millivolts,
					out_data.vcc_millivolts);
				compare_field("average_q6", oldest_result.average_q6, out_data.average_q6);
				compare_field("average_valid", oldest_result.average_valid,
					out_data.average_valid);
				compare_field("sample_count", oldest_result.sample_count, out_data.sample_count);
			end
		end
	end

	function automatic asa_pkg::in_word_t make_word(input logic [1:0] k,
			input logic [9:0] smp, input logic [2:0] sl);
		asa_pkg::in_word_t w;
		w.kind = k;
		w.sample = smp;
		w.slot = sl;
		return w;
	endfunction

	function automatic logic [9:0] random_sample();
		int r;
		r = $urandom_range(9, 0);
		if (r == 0) begin
			return 10'd0;
		end else if (r == 1) begin
			return 10'd1023;
		end
		return 10'($urandom);
	endfunction

	function automatic asa_pkg::in_word_t random_word();
		int r;
		logic [1:0] k;
		logic [2:0] sl;
		r = $urandom_range(99, 0);
		if (r < 60) begin
			k = asa_pkg::KIND_CONV;
		end else if (r < 78) begin
			k = asa_pkg::KIND_RAW;
		end else if (r < 95) begin
			k = asa_pkg::KIND_AVG;
		end else begin
			k = KIND_UNUSED;
		end
		sl = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
		return make_word(k, random_sample(), sl);
	endfunction

	// Valid stays high from one word to the next within a burst.
	task automatic send_word(input asa_pkg::in_word_t w);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(scan_and_average(w));
		if (gap_max > 0) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(gap_max, 1)) @(posedge clk);
				burst_left = $urandom_range(24, 1);
			end
		end
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_reg_write(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_unconfigured();
		send_word(make_word(asa_pkg::KIND_CONV, 10'd1023, 3'd0));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd0));
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd4));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd7));
		send_word(make_word(KIND_UNUSED, 10'd1023, 3'd5));
	endtask

	task automatic test_directed_scan();
		wait_results_done();
		write_reg(asa_pkg::REG_SLOT_COUNT, 5'd5);
		write_reg(asa_pkg::REG_SLOT0_CHAN, 5'd0);
		write_reg(asa_pkg::REG_SLOT0_CHAN + 3'd1, asa_pkg::BANDGAP_CHANNEL);
		write_reg(asa_pkg::REG_SLOT0_CHAN + 3'd2, 5'd15);
		write_reg(asa_pkg::REG_SLOT0_CHAN + 3'd3, 5'd31);
		write_reg(asa_pkg::REG_SLOT4_CHAN, 5'd17);
		stall_pct = 30;
		// Each slot takes one discarded and one kept conversion.
		send_word(make_word(asa_pkg::KIND_CONV, 10'd1023, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'd0, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'd0, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'd1, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'd5, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'd1023, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'h2AA, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'h155, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'd7, 3'd0));
		send_word(make_word(asa_pkg::KIND_CONV, 10'd512, 3'd0));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd0));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd1));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd2));
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd3));
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd3));
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd0));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd6));
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd5));
		send_word(make_word(KIND_UNUSED, 10'd0, 3'd0));
	endtask

	// One slot gets enough kept samples to reach the count ceiling and halve.
	task automatic test_count_saturation();
		wait_results_done();
		write_reg(asa_pkg::REG_SLOT_COUNT, 5'd1);
		write_reg(asa_pkg::REG_SLOT0_CHAN, 5'd9);
		stall_pct = 10;
		gap_max = 6;
		repeat (126) send_word(make_word(asa_pkg::KIND_CONV, random_sample(), 3'd0));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd0));
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd0));
		repeat (160) send_word(make_word(asa_pkg::KIND_CONV, random_sample(), 3'd0));
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd0));
	endtask

	task automatic test_register_rewrites();
		wait_results_done();
		write_reg(asa_pkg::REG_SLOT_COUNT, 5'd3);
		repeat (3) send_word(make_word(asa_pkg::KIND_CONV, random_sample(), 3'd0));
		wait_results_done();
		// Same count with the upper data bits set: the scan position is kept.
		write_reg(asa_pkg::REG_SLOT_COUNT, 5'b11011);
		repeat (2) send_word(make_word(asa_pkg::KIND_CONV, random_sample(), 3'd0));
		wait_results_done();
		write_reg(asa_pkg::REG_SLOT_COUNT, 5'd7);
		repeat (5) send_word(make_word(asa_pkg::KIND_CONV, random_sample(), 3'd0));
		wait_results_done();
		write_reg(asa_pkg::REG_SLOT0_CHAN + 3'd1, chan_q[1]);
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd1));
		repeat (6) send_word(make_word(asa_pkg::KIND_CONV, random_sample(), 3'd0));
		wait_results_done();
		write_reg(asa_pkg::REG_SLOT0_CHAN + 3'd1, chan_q[1] ^ 5'h14);
		send_word(make_word(asa_pkg::KIND_AVG, 10'd0, 3'd1));
		wait_results_done();
		write_reg(REG_SPARE_LO, 5'd31);
		write_reg(REG_SPARE_HI, 5'd31);
		write_reg(asa_pkg::REG_SLOT_COUNT, 5'd6);
		repeat (6) send_word(make_word(asa_pkg::KIND_CONV, random_sample(), 3'd0));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd4));
		wait_results_done();
		write_reg(asa_pkg::REG_SLOT_COUNT, 5'd0);
		repeat (2) send_word(make_word(asa_pkg::KIND_CONV, random_sample(), 3'd0));
		send_word(make_word(asa_pkg::KIND_RAW, 10'd0, 3'd3));
	endtask

	task automatic test_random_traffic();
		int r;
		logic [2:0] cnt;
		for (int phase = 0; phase < 10; phase++) begin
			wait_results_done();
			r = $urandom_range(9, 0);
			cnt = (r == 0) ? 3'd0 : (r == 9) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 1));
			write_reg(asa_pkg::REG_SLOT_COUNT, {2'($urandom), cnt});
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if ($urandom_range(1, 0) == 1) begin
					write_reg(asa_pkg::REG_SLOT0_CHAN + 3'(s), ($urandom_range(4, 0) == 0) ?
						asa_pkg::BANDGAP_CHANNEL : 5'($urandom));
				end
			end
			if ($urandom_range(3, 0) == 0) begin
				write_reg(3'($urandom_range(7, 6)), 5'($urandom));
			end
			case ($urandom_range(3, 0))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 80;
			endcase
			case ($urandom_range(2, 0))
				0: gap_max = 0;
				1: gap_max = 4;
				default: gap_max = 10;
			endcase
			for (int n = 0; n < 160; n++) begin
				send_word(random_word());
				if ($urandom_range(199, 0) == 0) begin
					wait_results_done();
				end
			end
		end
	endtask

	initial begin
		slot_count_q = '0;
		settle_q = 0;
		scan_q = '0;
		foreach (chan_q[s]) begin
			chan_q[s] = '0;
			raw_q[s] = '0;
			sum_q[s] = '0;
			count_q[s] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unconfigured();
		test_directed_scan();
		test_count_saturation();
		test_register_rewrites();
		test_random_traffic();
		wait_results_done();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/asa_pkg.sv
rtl/adc_scan_averager.sv
test/tb.sv
